// ----- hdl/mpab_pkg.sv -----
// Shared types, constants and codes for the multi-pattern automaton builder.
package mpab_pkg;

  localparam int MAX_NODES   = 512;
  localparam int MAX_SYMBOLS = 64;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = NODE_W + 1;
  localparam int SCNT_W      = SYM_W + 1;
  localparam int CADDR_W     = NODE_W + SYM_W;
  localparam int CENT_W      = NODE_W + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_BUILD  = 2'd2,
    REQ_LOOKUP = 2'd3
  } mpab_req_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_BAD_SYM   = 3'd2,
    STS_NOT_BUILT = 3'd3,
    STS_BUILT     = 3'd4
  } mpab_status_e;

  typedef enum logic [3:0] {
    ST_BLANK,
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_FIN,
    ST_LK_CHK,
    ST_BR_RD,
    ST_BR_CHK,
    ST_BQ_HEAD,
    ST_BQ_T,
    ST_BQ_F,
    ST_BQ_M,
    ST_BS_RDF,
    ST_BS_RDE,
    ST_BS_CHK,
    ST_EMIT,
    ST_EMIT_MARK
  } mpab_state_e;

  typedef struct packed {
    mpab_req_e         req_type;
    logic [SYM_W-1:0]  symbol;
    logic              pattern_last;
    logic [NODE_W-1:0] from_node;
  } mpab_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] next_node;
    logic              match_flag;
    logic [CNT_W-1:0]  node_count;
    mpab_status_e      status;
  } mpab_rsp_t;

  typedef struct packed {
    mpab_req_e         req_type;
    logic              sym_ok;
    logic [SYM_W-1:0]  symbol;
    logic              pattern_last;
    logic [NODE_W-1:0] from_node;
  } mpab_cmd_t;

endpackage

// ----- hdl/mpab_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mpab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mpab_front.sv -----
// Request intake: alphabet register and symbol range classification.
module mpab_front import mpab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  mpab_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [SYM_W-1:0] cfg_wdata_i,
  input  logic             init_busy_i,
  input  logic             q_full_i,
  output logic             push_o,
  output mpab_cmd_t        cmd_o,
  output logic [SYM_W-1:0] alpha_o
);

  logic [SYM_W-1:0] alpha_q, alpha_d;

  always_comb begin
    alpha_d = alpha_q;
    if (cfg_we_i) begin
      alpha_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= {SYM_W{1'b1}};
    end else begin
      alpha_q <= alpha_d;
    end
  end

  assign req_ready_o = !q_full_i && !init_busy_i;
  assign push_o      = req_valid_i && req_ready_o;
  assign alpha_o     = alpha_q;

  always_comb begin
    cmd_o.req_type     = req_i.req_type;
    cmd_o.sym_ok       = (req_i.symbol != '0) && (req_i.symbol <= alpha_q);
    cmd_o.symbol       = req_i.symbol;
    cmd_o.pattern_last = req_i.pattern_last;
    cmd_o.from_node    = req_i.from_node;
  end

endmodule

// ----- hdl/mpab_queue.sv -----
// Short command queue between intake and execution.
module mpab_queue import mpab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mpab_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output mpab_cmd_t cmd_o
);

  mpab_cmd_t           ent_q [QDEPTH];
  logic [QPTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/mpab_back.sv -----
// Execution sequencer: trie stores, breadth-first link pass and result register.
module mpab_back import mpab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mpab_cmd_t        cmd_i,
  output logic             pop_o,
  input  logic [SYM_W-1:0] alpha_i,
  output logic             init_busy_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output mpab_rsp_t        rsp_o
);

  mpab_state_e       state_q, state_d, ret_q, ret_d;
  mpab_cmd_t         cmd_q, cmd_d;
  logic              init_q, init_d;
  logic [NODE_W-1:0] bn_q, bn_d;
  logic [SYM_W-1:0]  bc_q, bc_d;
  logic [CNT_W-1:0]  nodes_q, nodes_d;
  logic [NODE_W-1:0] cursor_q, cursor_d;
  logic              built_q, built_d;
  logic [NODE_W-1:0] r_q, r_d, f_q, f_d, via_q, via_d;
  logic [SCNT_W-1:0] s_q, s_d;
  logic [CNT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0] res_node_q, res_node_d;
  logic              res_match_q, res_match_d;
  mpab_status_e      res_sts_q, res_sts_d;
  logic              out_valid_q, out_valid_d;
  mpab_rsp_t         out_q, out_d;

  logic               c_we;
  logic [CADDR_W-1:0] c_waddr, c_raddr;
  logic [CENT_W-1:0]  c_wdata, c_rdata;
  logic               f_we;
  logic [NODE_W-1:0]  f_waddr, f_wdata, f_raddr, f_rdata;
  logic               m_we;
  logic [NODE_W-1:0]  m_waddr, m_raddr;
  logic               m_wdata, m_rdata;
  logic               q_we;
  logic [NODE_W-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;

  logic              s_over, take, ins_rej, lk_ok;
  logic [NODE_W-1:0] lk_from, c_node;

  mpab_ram #(.WIDTH(CENT_W), .DEPTH(MAX_NODES * MAX_SYMBOLS)) u_child (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  mpab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  mpab_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );
  mpab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_bfsq (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign s_over  = (s_q > {1'b0, alpha_i});
  assign take    = (state_q == ST_IDLE) && !empty_i && !out_valid_q;
  assign pop_o   = take;
  assign ins_rej = built_q || !cmd_i.sym_ok;
  assign lk_ok   = built_q && cmd_i.sym_ok;
  assign lk_from = ({1'b0, cmd_i.from_node} >= nodes_q) ? '0 : cmd_i.from_node;
  assign c_node  = c_rdata[NODE_W-1:0];

  assign init_busy_o = init_q;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_BLANK:   if (bc_q == {SYM_W{1'b1}}) state_d = ret_q;
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.req_type)
            REQ_CLEAR:  state_d = ST_BLANK;
            REQ_INSERT: state_d = ins_rej ? ST_EMIT_MARK : ST_INS_CHK;
            REQ_BUILD:  state_d = built_q ? ST_EMIT : ST_BR_RD;
            REQ_LOOKUP: state_d = lk_ok ? ST_LK_CHK : ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_CHK: begin
        if (c_rdata[NODE_W]) begin
          state_d = ST_INS_FIN;
        end else if (nodes_q >= CNT_W'(MAX_NODES)) begin
          state_d = ST_EMIT_MARK;
        end else begin
          state_d = ST_BLANK;
        end
      end
      ST_INS_FIN: state_d = cmd_q.pattern_last ? ST_EMIT : ST_EMIT_MARK;
      ST_LK_CHK:  state_d = ST_EMIT_MARK;
      ST_BR_RD:   state_d = s_over ? ST_BQ_HEAD : ST_BR_CHK;
      ST_BR_CHK:  state_d = ST_BR_RD;
      ST_BQ_HEAD: state_d = (head_q < tail_q) ? ST_BQ_T : ST_EMIT;
      ST_BQ_T:    state_d = ST_BQ_F;
      ST_BQ_F:    state_d = ST_BQ_M;
      ST_BQ_M:    state_d = ST_BS_RDF;
      ST_BS_RDF:  state_d = s_over ? ST_BQ_HEAD : ST_BS_RDE;
      ST_BS_RDE:  state_d = ST_BS_CHK;
      ST_BS_CHK:  state_d = ST_BS_RDF;
      ST_EMIT:      state_d = ST_IDLE;
      ST_EMIT_MARK: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    cmd_d       = cmd_q;
    init_d      = init_q;
    ret_d       = ret_q;
    bn_d        = bn_q;
    bc_d        = bc_q;
    nodes_d     = nodes_q;
    cursor_d    = cursor_q;
    built_d     = built_q;
    r_d         = r_q;
    f_d         = f_q;
    via_d       = via_q;
    s_d         = s_q;
    head_d      = head_q;
    tail_d      = tail_q;
    res_node_d  = res_node_q;
    res_match_d = res_match_q;
    res_sts_d   = res_sts_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    m_we = 1'b0; m_waddr = '0; m_wdata = 1'b0; m_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_BLANK: begin
        c_we    = 1'b1;
        c_waddr = {bn_q, bc_q};
        if (bc_q == '0) begin
          f_we    = 1'b1;
          f_waddr = bn_q;
          m_we    = 1'b1;
          m_waddr = bn_q;
        end
        bc_d = bc_q + 1'b1;
        if (bc_q == {SYM_W{1'b1}}) begin
          init_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (take) begin
          cmd_d       = cmd_i;
          res_node_d  = '0;
          res_match_d = 1'b0;
          res_sts_d   = STS_OK;
          case (cmd_i.req_type)
            REQ_CLEAR: begin
              nodes_d  = CNT_W'(1);
              cursor_d = '0;
              built_d  = 1'b0;
              bn_d     = '0;
              bc_d     = '0;
              ret_d    = ST_EMIT;
            end
            REQ_INSERT: begin
              if (ins_rej) begin
                res_sts_d  = built_q ? STS_BUILT : STS_BAD_SYM;
                res_node_d = cursor_q;
                m_raddr    = cursor_q;
              end else begin
                c_raddr = {cursor_q, cmd_i.symbol};
              end
            end
            REQ_BUILD: begin
              if (built_q) begin
                res_sts_d = STS_BUILT;
              end else begin
                f_we   = 1'b1;
                s_d    = SCNT_W'(1);
                head_d = '0;
                tail_d = '0;
              end
            end
            REQ_LOOKUP: begin
              if (!built_q) begin
                res_sts_d = STS_NOT_BUILT;
              end else if (!cmd_i.sym_ok) begin
                res_sts_d = STS_BAD_SYM;
              end else begin
                c_raddr = {lk_from, cmd_i.symbol};
              end
            end
            default: res_sts_d = STS_OK;
          endcase
        end
      end
      ST_INS_CHK: begin
        if (c_rdata[NODE_W]) begin
          r_d = c_node;
        end else if (nodes_q >= CNT_W'(MAX_NODES)) begin
          res_sts_d  = STS_FULL;
          res_node_d = cursor_q;
          m_raddr    = cursor_q;
        end else begin
          nodes_d = nodes_q + 1'b1;
          c_we    = 1'b1;
          c_waddr = {cursor_q, cmd_q.symbol};
          c_wdata = {1'b1, nodes_q[NODE_W-1:0]};
          r_d     = nodes_q[NODE_W-1:0];
          bn_d    = nodes_q[NODE_W-1:0];
          bc_d    = '0;
          ret_d   = ST_INS_FIN;
        end
      end
      ST_INS_FIN: begin
        res_node_d = r_q;
        if (cmd_q.pattern_last) begin
          m_we        = 1'b1;
          m_waddr     = r_q;
          m_wdata     = 1'b1;
          res_match_d = 1'b1;
          cursor_d    = '0;
        end else begin
          cursor_d = r_q;
          m_raddr  = r_q;
        end
      end
      ST_LK_CHK: begin
        res_node_d = c_rdata[NODE_W] ? c_node : '0;
        m_raddr    = c_rdata[NODE_W] ? c_node : '0;
      end
      ST_BR_RD: begin
        c_raddr = {{NODE_W{1'b0}}, s_q[SYM_W-1:0]};
      end
      ST_BR_CHK: begin
        if (!c_rdata[NODE_W]) begin
          c_we    = 1'b1;
          c_waddr = {{NODE_W{1'b0}}, s_q[SYM_W-1:0]};
          c_wdata = {1'b1, {NODE_W{1'b0}}};
        end else begin
          f_we    = 1'b1;
          f_waddr = c_node;
          if (tail_q < CNT_W'(MAX_NODES)) begin
            q_we    = 1'b1;
            q_waddr = tail_q[NODE_W-1:0];
            q_wdata = c_node;
            tail_d  = tail_q + 1'b1;
          end
        end
        s_d = s_q + 1'b1;
      end
      ST_BQ_HEAD: begin
        if (head_q < tail_q) begin
          q_raddr = head_q[NODE_W-1:0];
          head_d  = head_q + 1'b1;
        end else begin
          built_d = 1'b1;
        end
      end
      ST_BQ_T: begin
        r_d     = q_rdata;
        f_raddr = q_rdata;
      end
      ST_BQ_F: begin
        f_d     = f_rdata;
        m_raddr = f_rdata;
      end
      ST_BQ_M: begin
        if (m_rdata) begin
          m_we    = 1'b1;
          m_waddr = r_q;
          m_wdata = 1'b1;
        end
        s_d = SCNT_W'(1);
      end
      ST_BS_RDF: begin
        c_raddr = {f_q, s_q[SYM_W-1:0]};
      end
      ST_BS_RDE: begin
        via_d   = c_rdata[NODE_W] ? c_node : '0;
        c_raddr = {r_q, s_q[SYM_W-1:0]};
      end
      ST_BS_CHK: begin
        if (!c_rdata[NODE_W]) begin
          c_we    = 1'b1;
          c_waddr = {r_q, s_q[SYM_W-1:0]};
          c_wdata = {1'b1, via_q};
        end else begin
          f_we    = 1'b1;
          f_waddr = c_node;
          f_wdata = via_q;
          if (tail_q < CNT_W'(MAX_NODES)) begin
            q_we    = 1'b1;
            q_waddr = tail_q[NODE_W-1:0];
            q_wdata = c_node;
            tail_d  = tail_q + 1'b1;
          end
        end
        s_d = s_q + 1'b1;
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        out_d       = '{res_node_q, res_match_q, nodes_q, res_sts_q};
      end
      ST_EMIT_MARK: begin
        out_valid_d = 1'b1;
        out_d       = '{res_node_q, m_rdata, nodes_q, res_sts_q};
      end
      default: out_valid_d = out_valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BLANK;
      ret_q       <= ST_IDLE;
      init_q      <= 1'b1;
      bn_q        <= '0;
      bc_q        <= '0;
      nodes_q     <= CNT_W'(1);
      cursor_q    <= '0;
      built_q     <= 1'b0;
      s_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      init_q      <= init_d;
      bn_q        <= bn_d;
      bc_q        <= bc_d;
      nodes_q     <= nodes_d;
      cursor_q    <= cursor_d;
      built_q     <= built_d;
      s_q         <= s_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    r_q         <= r_d;
    f_q         <= f_d;
    via_q       <= via_d;
    res_node_q  <= res_node_d;
    res_match_q <= res_match_d;
    res_sts_q   <= res_sts_d;
    out_q       <= out_d;
  end

endmodule

// ----- hdl/multi_pattern_automaton_builder.sv -----
// Top level of the multi-pattern automaton builder.
// An insert that allocates a node blanks that node's child row first; clear blanks the root row.
// Build completes the root row, then sets fail links and transitions for each queued node
// in breadth-first order over all symbols of the alphabet.
// The sequencer executes one request at a time.
// Reset is asynchronous, active low; afterwards a pass blanks the root row,
// during which no request is taken. Alphabet size resets to 63.
module multi_pattern_automaton_builder import mpab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  mpab_req_t        req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output mpab_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic [SYM_W-1:0] cfg_wdata_i
);

  logic             init_busy, q_full, q_empty, push, pop;
  logic [SYM_W-1:0] alpha;
  mpab_cmd_t        cmd_in, cmd_out;

  mpab_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i, .cfg_we_i, .cfg_wdata_i,
    .init_busy_i(init_busy), .q_full_i(q_full), .push_o(push), .cmd_o(cmd_in),
    .alpha_o(alpha)
  );

  mpab_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .cmd_o(cmd_out)
  );

  mpab_back u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .cmd_i(cmd_out), .pop_o(pop),
    .alpha_i(alpha), .init_busy_o(init_busy), .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

endmodule

// ----- hdl/mpab_checker.sv -----
// Port-level checks for the automaton builder and their binding.
module mpab_checker import mpab_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      rsp_valid_i,
  input logic      rsp_ready_i,
  input mpab_rsp_t rsp_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("response dropped or changed while stalled");

  a_sts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_i.status != 3'd5 && rsp_i.status != 3'd6 && rsp_i.status != 3'd7)
    else $error("undefined status code");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_i.node_count != '0)
    else $error("node count lost the root");

  a_not_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status == STS_NOT_BUILT |-> rsp_i.next_node == '0 && !rsp_i.match_flag)
    else $error("lookup before build returned a node");

endmodule

bind multi_pattern_automaton_builder mpab_checker u_mpab_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .rsp_valid_i(rsp_valid_o),
  .rsp_ready_i(rsp_ready_i), .rsp_i(rsp_o)
);

// ----- tb/sv/multi_pattern_automaton_builder_tb.sv -----
// Self-checking testbench for the multi-pattern automaton builder.
module multi_pattern_automaton_builder_tb;
  import mpab_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  class automaton_scoreboard;
    bit [NODE_W-1:0] child[MAX_NODES*MAX_SYMBOLS];
    bit              child_ok[MAX_NODES*MAX_SYMBOLS];
    bit [NODE_W-1:0] fail_link[MAX_NODES];
    bit              mark[MAX_NODES];
    int              used;
    int              cursor;
    bit              built;
    int              alpha;
    mpab_rsp_t       expected_q[$];
    int              errors;
    int              results;
    int              last_next;

    function new();
      alpha = 63;
      errors = 0;
      results = 0;
      last_next = 0;
      clear_trie();
    endfunction

    function void blank_node(int n);
      for (int s = 0; s < MAX_SYMBOLS; s++) begin
        child_ok[n*MAX_SYMBOLS+s] = 0;
        child[n*MAX_SYMBOLS+s] = '0;
      end
      fail_link[n] = '0;
      mark[n] = 0;
    endfunction

    function void clear_trie();
      blank_node(0);
      used = 1;
      cursor = 0;
      built = 0;
    endfunction

    function void build_links();
      int q[MAX_NODES];
      int head, tail, t, f, e, fe, via;
      head = 0;
      tail = 0;
      fail_link[0] = '0;
      for (int s = 1; s <= alpha; s++) begin
        if (!child_ok[s]) begin
          child_ok[s] = 1;
          child[s] = '0;
        end else begin
          fail_link[child[s]] = '0;
          if (tail < MAX_NODES) begin
            q[tail] = child[s];
            tail++;
          end
        end
      end
      while (head < tail) begin
        t = q[head];
        head++;
        f = fail_link[t];
        if (mark[f]) mark[t] = 1;
        for (int s = 1; s <= alpha; s++) begin
          e = t*MAX_SYMBOLS + s;
          fe = f*MAX_SYMBOLS + s;
          via = child_ok[fe] ? child[fe] : 0;
          if (!child_ok[e]) begin
            child_ok[e] = 1;
            child[e] = NODE_W'(via);
          end else begin
            fail_link[child[e]] = NODE_W'(via);
            if (tail < MAX_NODES) begin
              q[tail] = child[e];
              tail++;
            end
          end
        end
      end
      built = 1;
    endfunction

    function mpab_rsp_t next_response(mpab_req_t r);
      mpab_rsp_t rsp;
      int sym, from, e, n;
      bit sym_ok;
      sym = r.symbol;
      from = r.from_node;
      sym_ok = (sym >= 1) && (sym <= alpha);
      rsp.next_node = '0;
      rsp.match_flag = 0;
      rsp.status = STS_OK;
      case (r.req_type)
        REQ_CLEAR: clear_trie();
        REQ_INSERT: begin
          if (built) rsp.status = STS_BUILT;
          else if (!sym_ok) rsp.status = STS_BAD_SYM;
          else begin
            e = cursor*MAX_SYMBOLS + sym;
            if (!child_ok[e]) begin
              if (used >= MAX_NODES) rsp.status = STS_FULL;
              else begin
                n = used;
                used++;
                blank_node(n);
                child_ok[e] = 1;
                child[e] = NODE_W'(n);
              end
            end
            if (rsp.status == STS_OK) begin
              n = child[e];
              if (r.pattern_last) mark[n] = 1;
              rsp.next_node = NODE_W'(n);
              rsp.match_flag = mark[n];
              cursor = r.pattern_last ? 0 : n;
            end
          end
          if (rsp.status != STS_OK) begin
            rsp.next_node = NODE_W'(cursor);
            rsp.match_flag = mark[cursor];
          end
        end
        REQ_BUILD: begin
          if (built) rsp.status = STS_BUILT;
          else build_links();
        end
        default: begin
          if (!built) rsp.status = STS_NOT_BUILT;
          else if (!sym_ok) rsp.status = STS_BAD_SYM;
          else begin
            if (from >= used) from = 0;
            e = from*MAX_SYMBOLS + sym;
            n = child_ok[e] ? child[e] : 0;
            rsp.next_node = NODE_W'(n);
            rsp.match_flag = mark[n];
          end
        end
      endcase
      rsp.node_count = CNT_W'(used);
      return rsp;
    endfunction

    function void note_request(mpab_req_t r);
      mpab_rsp_t rsp;
      rsp = next_response(r);
      last_next = rsp.next_node;
      expected_q.push_back(rsp);
    endfunction

    function void check_response(mpab_rsp_t got);
      mpab_rsp_t exp_rsp;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected response: next_node %0d status %0d", got.next_node, got.status);
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.next_node !== exp_rsp.next_node) begin
        $error("next_node: expected %0d, got %0d", exp_rsp.next_node, got.next_node);
        errors++;
      end
      if (got.match_flag !== exp_rsp.match_flag) begin
        $error("match_flag: expected %0d, got %0d", exp_rsp.match_flag, got.match_flag);
        errors++;
      end
      if (got.node_count !== exp_rsp.node_count) begin
        $error("node_count: expected %0d, got %0d", exp_rsp.node_count, got.node_count);
        errors++;
      end
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             req_valid_i;
  logic             req_ready_o;
  mpab_req_t        req_i;
  logic             rsp_valid_o;
  logic             rsp_ready_i;
  mpab_rsp_t        rsp_o;
  logic             cfg_we_i;
  logic [SYM_W-1:0] cfg_wdata_i;

  automaton_scoreboard sb;
  int  cycles;
  int  sent;
  int  burst_left;
  int  phases;
  bit  long_hold;
  int  hold_cnt;
  int  stall_mode;

  multi_pattern_automaton_builder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
  end

  // hold off on request of the stimulus, otherwise stall on a changing pattern
  initial begin
    rsp_ready_i = 1'b0;
    hold_cnt = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      if (cycles % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (long_hold) begin
        hold_cnt = 400;
        long_hold = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_ready_i <= 1'b1;
          1: rsp_ready_i <= 1'($urandom_range(0, 1));
          default: rsp_ready_i <= (cycles % 4 != 0);
        endcase
      end
    end
  end

  function automatic mpab_req_t mk(mpab_req_e kind, int sym, bit last, int from);
    mpab_req_t r;
    r.req_type = kind;
    r.symbol = SYM_W'(sym);
    r.pattern_last = last;
    r.from_node = NODE_W'(from);
    return r;
  endfunction

  task automatic send(mpab_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk_i);
        req_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
    sent++;
    burst_left--;
  endtask

  task automatic write_alphabet(int value);
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= SYM_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.alpha = value;
  endtask

  function automatic int pick_symbol(int alpha, int narrow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 8 && alpha < 63) return $urandom_range(alpha + 1, 63);
    return $urandom_range(1, (narrow < alpha) ? narrow : alpha);
  endfunction

  task automatic insert_patterns(int npat, int maxlen, int narrow);
    int len;
    for (int p = 0; p < npat; p++) begin
      len = $urandom_range(1, maxlen);
      for (int k = 0; k < len; k++)
        send(mk(REQ_INSERT, pick_symbol(sb.alpha, narrow), k == len - 1, $urandom_range(0, 511)));
      if ($urandom_range(0, 19) == 0)
        send(mk(mpab_req_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                $urandom_range(0, 1), $urandom_range(0, 511)));
    end
  endtask

  task automatic walk_text(int n, int narrow);
    int from;
    for (int k = 0; k < n; k++) begin
      from = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : sb.last_next;
      send(mk(REQ_LOOKUP, pick_symbol(sb.alpha, narrow), $urandom_range(0, 1), from));
    end
  endtask

  task automatic run_phase(int alpha);
    int narrow;
    phases++;
    write_alphabet(alpha);
    narrow = $urandom_range(1, 4);
    send(mk(REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 511)));
    if ($urandom_range(0, 3) == 0) walk_text(2, narrow);
    insert_patterns($urandom_range(2, 8), $urandom_range(2, 8), narrow);
    send(mk(REQ_BUILD, $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 511)));
    if ($urandom_range(0, 4) == 0) begin
      send(mk(REQ_BUILD, 0, 0, 0));
      send(mk(REQ_INSERT, pick_symbol(alpha, narrow), $urandom_range(0, 1), 0));
    end
    walk_text($urandom_range(20, 60), narrow);
    if (alpha < 63 && $urandom_range(0, 2) == 0) begin
      write_alphabet($urandom_range(alpha + 1, 63));
      walk_text($urandom_range(5, 15), alpha + 2);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    burst_left = 0;
    phases = 0;
    long_hold = 0;
    req_valid_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send(mk(REQ_LOOKUP, 1, 0, 0));
    send(mk(REQ_INSERT, 0, 1, 0));
    send(mk(REQ_INSERT, 63, 0, 0));
    send(mk(REQ_INSERT, 1, 1, 0));
    send(mk(REQ_INSERT, 1, 0, 0));
    send(mk(REQ_INSERT, 63, 1, 511));
    send(mk(REQ_BUILD, 0, 0, 0));
    send(mk(REQ_BUILD, 0, 0, 0));
    send(mk(REQ_INSERT, 5, 1, 0));
    send(mk(REQ_LOOKUP, 63, 0, 0));
    send(mk(REQ_LOOKUP, 1, 1, 511));
    send(mk(REQ_LOOKUP, 0, 0, 1));
    send(mk(REQ_LOOKUP, 63, 0, 3));
    write_alphabet(1);
    send(mk(REQ_LOOKUP, 2, 0, 0));
    send(mk(REQ_CLEAR, 0, 0, 0));
    send(mk(REQ_INSERT, 2, 1, 0));
    send(mk(REQ_INSERT, 1, 0, 0));
    send(mk(REQ_INSERT, 1, 1, 0));
    send(mk(REQ_BUILD, 0, 0, 0));
    write_alphabet(63);
    send(mk(REQ_LOOKUP, 40, 0, 1));
    send(mk(REQ_LOOKUP, 1, 0, 2));

    // fill the node store to its limit over a narrow alphabet
    write_alphabet(2);
    send(mk(REQ_CLEAR, 0, 0, 0));
    while (sb.used < MAX_NODES) begin
      if (sb.built) send(mk(REQ_CLEAR, 0, 0, 0));
      insert_patterns(1, 40, 2);
    end
    insert_patterns(4, 30, 2);
    send(mk(REQ_BUILD, 0, 0, 0));
    long_hold = 1;
    walk_text(60, 2);

    run_phase(1);
    run_phase(63);
    while (sent < 1950) run_phase($urandom_range(0, 3) == 0 ? 63 : $urandom_range(1, 63));

    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests over %0d phases, %0d responses checked.", sent, phases,
             sb.results);
    $display("Covered clear, insert, build and lookup, full store and alphabet changes.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mpab_pkg.sv
hdl/mpab_ram.sv
hdl/mpab_front.sv
hdl/mpab_queue.sv
hdl/mpab_back.sv
hdl/multi_pattern_automaton_builder.sv
hdl/mpab_checker.sv
tb/sv/multi_pattern_automaton_builder_tb.sv
